>>> rtl/assert_macros.svh
// Assertion helpers, included by the array unit RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies the consequent in the next one.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/iiar_pkg.sv
`default_nettype none
package iiar_pkg;

  localparam int CAPACITY      = 64;
  localparam int DATA_W        = 32;
  localparam int ELEMENT_WIDTH = DATA_W;
  localparam int OP_W          = 3;
  localparam int POS_W         = 7;
  localparam int STATUS_W      = 2;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int CMP_W         = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int LEAF          = 8;
  localparam int NGROUP        = (CAPACITY + LEAF - 1) / LEAF;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_POSITION = 2'd1,
    ST_FULL         = 2'd2,
    ST_EMPTY        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SET    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] wdata;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/iiar_cell.sv
`default_nettype none
module iiar_cell (
  input  wire                               clk_i,
  input  wire  [iiar_pkg::IDX_W-1:0]        idx_i,
  input  wire  iiar_pkg::cell_ctrl_t        ctrl_i,
  input  wire  [iiar_pkg::ELEMENT_WIDTH-1:0] left_i,
  input  wire  [iiar_pkg::ELEMENT_WIDTH-1:0] right_i,
  output logic [iiar_pkg::ELEMENT_WIDTH-1:0] data_o,
  output logic [iiar_pkg::ELEMENT_WIDTH-1:0] rd_o
);

  logic [iiar_pkg::ELEMENT_WIDTH-1:0] data_q, data_d;
  logic [iiar_pkg::POS_W:0]           idx_ext, pos_ext;
  logic                               at_pos, above_pos;

  assign idx_ext   = (iiar_pkg::POS_W + 1)'(idx_i);
  assign pos_ext   = (iiar_pkg::POS_W + 1)'(ctrl_i.pos);
  assign at_pos    = (idx_ext == pos_ext);
  assign above_pos = (idx_ext > pos_ext);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.cmd)
      iiar_pkg::CMD_INSERT: begin
        if (above_pos) data_d = left_i;
        else if (at_pos) data_d = ctrl_i.wdata;
      end
      iiar_pkg::CMD_REMOVE: begin
        if (above_pos || at_pos) data_d = right_i;
      end
      iiar_pkg::CMD_SET: begin
        if (at_pos) data_d = ctrl_i.wdata;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the addressed cell puts its value on the read tree.
  assign rd_o   = at_pos ? data_q : '0;

endmodule
`default_nettype wire

>>> rtl/iiar_read_tree.sv
`default_nettype none
module iiar_read_tree (
  input  wire                                clk_i,
  input  wire                                load_i,
  input  wire  [iiar_pkg::ELEMENT_WIDTH-1:0] rd_i [iiar_pkg::CAPACITY],
  output logic [iiar_pkg::ELEMENT_WIDTH-1:0] data_o
);

  logic [iiar_pkg::ELEMENT_WIDTH-1:0] grp_q [iiar_pkg::NGROUP];
  logic [iiar_pkg::ELEMENT_WIDTH-1:0] grp_d [iiar_pkg::NGROUP];

  always_comb begin
    for (int g = 0; g < iiar_pkg::NGROUP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < iiar_pkg::LEAF; k++) begin
        if (g * iiar_pkg::LEAF + k < iiar_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | rd_i[g * iiar_pkg::LEAF + k];
        end
      end
    end
  end

  // The first level is captured together with the cell update, so it holds
  // the values from before any shift.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < iiar_pkg::NGROUP; g++) begin
      data_o = data_o | grp_q[g];
    end
  end

endmodule
`default_nettype wire

>>> rtl/indexed_insert_remove_array_unit.sv
// A transaction accepted in idle runs an execute step and then a read step, set by the
// two-level read tree (registered first level) over the cell chain; the next one is
// accepted only after the result has been loaded into the output register.
// A new transaction is taken while the previous result still waits at the output.
// Reset clears the element count, the sequencer and the output valid flag.
// Cell contents are left undefined by reset; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module indexed_insert_remove_array_unit (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [iiar_pkg::OP_W-1:0]       operation_i,
  input  wire  [iiar_pkg::POS_W-1:0]      position_i,
  input  wire  [iiar_pkg::DATA_W-1:0]     write_data_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [iiar_pkg::STATUS_W-1:0]   status_o,
  output logic [iiar_pkg::DATA_W-1:0]     read_data_o,
  output logic [iiar_pkg::CNT_W-1:0]      live_count_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_e;

  state_e                            state_q, state_d;
  logic [iiar_pkg::OP_W-1:0]         op_q;
  logic [iiar_pkg::POS_W-1:0]        pos_q;
  logic [iiar_pkg::DATA_W-1:0]       wdata_q;
  logic [iiar_pkg::CNT_W-1:0]        count_q, count_d;
  iiar_pkg::status_e                 status_q, status_d;
  logic                              rd_en_q, rd_en_d;
  iiar_pkg::cell_ctrl_t              ctrl;
  logic [iiar_pkg::CMP_W-1:0]        pos_c, cnt_c;
  logic                              out_valid_q;
  logic [iiar_pkg::STATUS_W-1:0]     out_status_q;
  logic [iiar_pkg::DATA_W-1:0]       out_data_q;
  logic [iiar_pkg::CNT_W-1:0]        out_count_q;
  logic                              out_load;
  logic [iiar_pkg::ELEMENT_WIDTH-1:0] cell_data [iiar_pkg::CAPACITY];
  logic [iiar_pkg::ELEMENT_WIDTH-1:0] cell_rd   [iiar_pkg::CAPACITY];
  logic [iiar_pkg::ELEMENT_WIDTH-1:0] tree_data;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_READ) && (!out_valid_q || out_ready_i);

  assign pos_c = iiar_pkg::CMP_W'(pos_q);
  assign cnt_c = iiar_pkg::CMP_W'(count_q);

  // Decode of the held transaction against the current count.
  always_comb begin
    ctrl.cmd   = iiar_pkg::CMD_HOLD;
    ctrl.pos   = pos_q;
    ctrl.wdata = wdata_q;
    status_d   = iiar_pkg::ST_OK;
    rd_en_d    = 1'b0;
    count_d    = count_q;
    case (op_q)
      iiar_pkg::OP_INSERT: begin
        if (pos_c > cnt_c) status_d = iiar_pkg::ST_BAD_POSITION;
        else if (count_q == iiar_pkg::CNT_W'(iiar_pkg::CAPACITY))
          status_d = iiar_pkg::ST_FULL;
        else begin
          ctrl.cmd = iiar_pkg::CMD_INSERT;
          count_d  = count_q + 1'b1;
        end
      end
      iiar_pkg::OP_REMOVE: begin
        if (count_q == '0) status_d = iiar_pkg::ST_EMPTY;
        else if (pos_c >= cnt_c) status_d = iiar_pkg::ST_BAD_POSITION;
        else begin
          ctrl.cmd = iiar_pkg::CMD_REMOVE;
          rd_en_d  = 1'b1;
          count_d  = count_q - 1'b1;
        end
      end
      iiar_pkg::OP_GET: begin
        if (pos_c >= cnt_c) status_d = iiar_pkg::ST_BAD_POSITION;
        else rd_en_d = 1'b1;
      end
      iiar_pkg::OP_SET: begin
        if (pos_c >= cnt_c) status_d = iiar_pkg::ST_BAD_POSITION;
        else ctrl.cmd = iiar_pkg::CMD_SET;
      end
      iiar_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    if (state_q != S_EXEC) begin
      ctrl.cmd = iiar_pkg::CMD_HOLD;
      count_d  = count_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = S_READ;
      S_READ: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= operation_i;
      pos_q   <= position_i;
      wdata_q <= write_data_i;
    end
    if (state_q == S_EXEC) begin
      status_q <= status_d;
      rd_en_q  <= rd_en_d;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_data_q   <= rd_en_q ? tree_data : '0;
      out_count_q  <= count_q;
    end
  end

  for (genvar i = 0; i < iiar_pkg::CAPACITY; i++) begin : g_cell
    logic [iiar_pkg::ELEMENT_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == iiar_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    iiar_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (iiar_pkg::IDX_W'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  iiar_read_tree u_read_tree (
    .clk_i  (clk_i),
    .load_i (state_q == S_EXEC),
    .rd_i   (cell_rd),
    .data_o (tree_data)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_data_o  = out_data_q;
  assign live_count_o = out_count_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= iiar_pkg::CNT_W'(iiar_pkg::CAPACITY))
  `ASSERT_ALWAYS(a_state_onehot, $onehot(state_q))
  `ASSERT_NEXT(a_accept_exec, in_valid_i && in_ready_o, state_q == S_EXEC)
  `ASSERT_NEXT(a_exec_read, state_q == S_EXEC, state_q == S_READ)
  `ASSERT_ALWAYS(a_fail_no_data,
    !(out_valid_o && (status_o != iiar_pkg::ST_OK)) || (read_data_o == '0))

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import iiar_pkg::*;

  localparam int RANDOM_ITEMS    = 1400;
  localparam int QUIET_ITEMS     = 200;
  localparam int SEGMENT_ITEMS   = 100;
  localparam int HOLD_OFF_ITEM   = 150;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES    = 12;
  localparam int MAX_REPORTS     = 10;
  localparam int DIRECTED_ROWS   = 26;

  // Operation codes that the block treats as no operation.
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  read_data;
    logic [CNT_W-1:0]   live_count;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  data;
    logic [7:0]         reps;
    logic               typed;
    status_e            status;
    logic [DATA_W-1:0]  read_data;
    logic [CNT_W-1:0]   live_count;
  } directed_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OP_W-1:0]      operation_i;
  logic [POS_W-1:0]     position_i;
  logic [DATA_W-1:0]    write_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STATUS_W-1:0]  status_o;
  logic [DATA_W-1:0]    read_data_o;
  logic [CNT_W-1:0]     live_count_o;

  logic [DATA_W-1:0]    stored_elements[$];
  result_t              expected_results[$];
  int unsigned          mismatch_count = 0;
  int unsigned          idle_pct = 0;
  bit                   hold_off_request = 1'b0;
  directed_row_t        directed_rows[DIRECTED_ROWS];

  indexed_insert_remove_array_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .position_i  (position_i),
    .write_data_i(write_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .read_data_o (read_data_o),
    .live_count_o(live_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Applies one operation to the array copy and returns the result it gives.
  function automatic result_t apply_array_op(input logic [OP_W-1:0] op,
                                             input logic [POS_W-1:0] pos,
                                             input logic [DATA_W-1:0] data);
    result_t     res;
    int unsigned count;
    count = stored_elements.size();
    res.status = ST_OK;
    res.read_data = '0;
    case (op)
      OP_INSERT: begin
        if (pos > count) res.status = ST_BAD_POSITION;
        else if (count >= CAPACITY) res.status = ST_FULL;
        else stored_elements.insert(int'(pos), data);
      end
      OP_REMOVE: begin
        if (count == 0) res.status = ST_EMPTY;
        else if (pos >= count) res.status = ST_BAD_POSITION;
        else begin
          res.read_data = stored_elements[pos];
          stored_elements.delete(int'(pos));
        end
      end
      OP_GET: begin
        if (pos >= count) res.status = ST_BAD_POSITION;
        else res.read_data = stored_elements[pos];
      end
      OP_SET: begin
        if (pos >= count) res.status = ST_BAD_POSITION;
        else stored_elements[pos] = data;
      end
      OP_CLEAR: stored_elements.delete();
      default: ;
    endcase
    res.live_count = CNT_W'(stored_elements.size());
    return res;
  endfunction

  // Picks one of the codes that have no operation behind them.
  function automatic logic [OP_W-1:0] OP_OP_SPARE_PICK();
    return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  // Called just after the rising clock; returns right after the block has taken the transaction.
  task automatic offer_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] data, input logic typed,
                            input result_t typed_result);
    result_t     predicted;
    int unsigned gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    position_i   <= pos;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_array_op(op, pos, data);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch %0d at %0t: %s expected %h, got %h",
               mismatch_count, $time, what, want, got);
    end
  endtask

  initial begin
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    int unsigned       count;
    int unsigned       fill_target;
    int unsigned       pick;
    directed_row_t     row;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = '0;
    position_i   = '0;
    write_data_i = '0;

    // Rows with typed results come straight from the rules; the rest use the predictor.
    directed_rows = '{
      '{OP_REMOVE,   7'd0,   32'h0000_0000, 8'd1,  1'b1, ST_EMPTY,        32'd0, 7'd0},
      '{OP_GET,      7'd0,   32'h0000_0000, 8'd1,  1'b1, ST_BAD_POSITION, 32'd0, 7'd0},
      '{OP_SET,      7'd0,   32'hFFFF_FFFF, 8'd1,  1'b1, ST_BAD_POSITION, 32'd0, 7'd0},
      '{OP_INSERT,   7'd1,   32'h1234_5678, 8'd1,  1'b1, ST_BAD_POSITION, 32'd0, 7'd0},
      '{OP_INSERT,   7'd0,   32'hFFFF_FFFF, 8'd1,  1'b1, ST_OK,           32'd0, 7'd1},
      '{OP_INSERT,   7'd1,   32'h0000_0000, 8'd1,  1'b1, ST_OK,           32'd0, 7'd2},
      '{OP_INSERT,   7'd1,   32'hA5A5_A5A5, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_GET,      7'd2,   32'h0000_0000, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_SET,      7'd0,   32'h5A5A_5A5A, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_GET,      7'd0,   32'h0000_0000, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_GET,      7'd127, 32'h0000_0000, 8'd1,  1'b1, ST_BAD_POSITION, 32'd0, 7'd3},
      '{OP_REMOVE,   7'd3,   32'h0000_0000, 8'd1,  1'b1, ST_BAD_POSITION, 32'd0, 7'd3},
      '{OP_REMOVE,   7'd1,   32'h0000_0000, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_SPARE_LO, 7'd0,   32'hFFFF_FFFF, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_SPARE_MID,7'd64,  32'h0000_0000, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_SPARE_HI, 7'd127, 32'hFFFF_FFFF, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_CLEAR,    7'd127, 32'h0000_0000, 8'd1,  1'b1, ST_OK,           32'd0, 7'd0},
      '{OP_REMOVE,   7'd5,   32'h0000_0000, 8'd1,  1'b1, ST_EMPTY,        32'd0, 7'd0},
      '{OP_INSERT,   7'd0,   32'h8000_0001, 8'd64, 1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_INSERT,   7'd64,  32'h0000_0000, 8'd1,  1'b1, ST_FULL,         32'd0, 7'd64},
      '{OP_INSERT,   7'd65,  32'h0000_0000, 8'd1,  1'b1, ST_BAD_POSITION, 32'd0, 7'd64},
      '{OP_INSERT,   7'd0,   32'hFFFF_FFFF, 8'd1,  1'b1, ST_FULL,         32'd0, 7'd64},
      '{OP_SET,      7'd63,  32'hFFFF_FFFF, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_REMOVE,   7'd63,  32'h0000_0000, 8'd1,  1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_REMOVE,   7'd0,   32'h0000_0000, 8'd63, 1'b0, ST_OK,           32'd0, 7'd0},
      '{OP_GET,      7'd0,   32'h0000_0000, 8'd1,  1'b1, ST_BAD_POSITION, 32'd0, 7'd0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int k = 0; k < row.reps; k++) begin
        offer_item(row.op, row.pos, row.data + DATA_W'(k), row.typed,
                   result_t'{row.status, row.read_data, row.live_count});
      end
    end

    fill_target = CAPACITY;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 10;
          2: idle_pct = 25;
          default: idle_pct = 50;
        endcase
        case ($urandom_range(0, 3))
          0: fill_target = 0;
          1: fill_target = CAPACITY;
          default: fill_target = $urandom_range(0, CAPACITY);
        endcase
      end
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) idle_pct = 0;
      // The receiver stalls for a long stretch while transactions keep coming.
      if (n == HOLD_OFF_ITEM) hold_off_request = 1'b1;

      count = stored_elements.size();
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 5) op = OP_OP_SPARE_PICK();
      else begin
        pick = $urandom_range(0, 99);
        if (pick < ((count < fill_target) ? 50 : 20)) op = OP_INSERT;
        else if (pick < 70) op = (count > fill_target) ? OP_REMOVE : OP_GET;
        else if (pick < 85) op = OP_SET;
        else op = (count > fill_target) ? OP_GET : OP_REMOVE;
      end

      // Mostly positions that the operation accepts, now and then any position.
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 127));
      else if (op == OP_INSERT) pos = POS_W'($urandom_range(0, count));
      else pos = POS_W'((count == 0) ? 0 : $urandom_range(0, count - 1));

      offer_item(op, pos, DATA_W'($urandom), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result with no transaction pending, status", '0, DATA_W'(status_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          note_mismatch("status", DATA_W'(want.status), DATA_W'(status_o));
        end
        if (read_data_o !== want.read_data) begin
          note_mismatch("read_data", want.read_data, read_data_o);
        end
        if (live_count_o !== want.live_count) begin
          note_mismatch("live_count", DATA_W'(want.live_count), DATA_W'(live_count_o));
        end
      end
    end
  end

endmodule
`default_nettype wire
